[src/bab_pkg.sv]
// ---------------------------------------------------------------------------
// bab_pkg
// Shared types and constants for the button adjusted blink timer.
// ---------------------------------------------------------------------------
package bab_pkg;

  localparam int TIMER_COUNT = 5;
  localparam int TIMER_W     = 16;
  localparam int ELAPSED_W   = 10;
  localparam int REG_IDX_W   = 3;

  // timer slots
  localparam int T_WINDOW = 0;
  localparam int T_UP     = 1;
  localparam int T_DOWN   = 2;
  localparam int T_BOTH   = 3;
  localparam int T_BLINK  = 4;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_STEP     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_MIN      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_MAX      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_START    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_INTERVAL = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POLL_INTERVAL   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOTH_INTERVAL   = 3'd6;

  // register reset values
  localparam logic [TIMER_W-1:0] RST_PERIOD_STEP     = 16'd100;
  localparam logic [TIMER_W-1:0] RST_PERIOD_MIN      = 16'd100;
  localparam logic [TIMER_W-1:0] RST_PERIOD_MAX      = 16'd2000;
  localparam logic [TIMER_W-1:0] RST_PERIOD_START    = 16'd1000;
  localparam logic [TIMER_W-1:0] RST_WINDOW_INTERVAL = 16'd500;
  localparam logic [TIMER_W-1:0] RST_POLL_INTERVAL   = 16'd200;
  localparam logic [TIMER_W-1:0] RST_BOTH_INTERVAL   = 16'd100;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_ms;
    logic                 up_pressed;
    logic                 down_pressed;
  } tick_t;

  typedef struct packed {
    logic               led_level;
    logic               running;
    logic [TIMER_W-1:0] half_period;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] addr;
    logic [TIMER_W-1:0]   data;
  } cfg_word_t;

endpackage

[src/bab_stream_if.sv]
// ---------------------------------------------------------------------------
// bab_stream_if
// Valid/ready channel carrying one word of type T.
// ---------------------------------------------------------------------------
interface bab_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/button_adjusted_blink_timer.sv]
// ---------------------------------------------------------------------------
// button_adjusted_blink_timer
// Tick-driven blink timer whose half period is nudged by two buttons.
// ---------------------------------------------------------------------------
// Each tick word (elapsed_ms, up_pressed, down_pressed) produces exactly one
// result word (led_level, running, half_period). Ticks pass through an input
// register and are processed combinationally into the result register, so one
// tick is taken every clock while the result side keeps up. The result word
// is loaded into the result register as its tick leaves the input register.
// A stalled result holds the pipe; the
// input register still takes one more tick. Config writes (cfg channel,
// always ready) are meant to land while no tick is in flight; index 7 is
// ignored. A period_start write is accepted but never shows: reset reloads
// its default, and the half period is only loaded at reset. Once the both
// timer fires with both buttons seen inside the current window, the block
// stops for good (until rst), driving the LED on unless the blink fires in
// that same tick; only the internal timers keep counting. All timers saturate at 65535 ms.
// ---------------------------------------------------------------------------
module button_adjusted_blink_timer (
  input  logic         clk,
  input  logic         rst,
  bab_stream_if.sink   tick,
  bab_stream_if.source result,
  bab_stream_if.sink   cfg
);
  import bab_pkg::*;

  // config registers
  logic [TIMER_W-1:0] period_step;
  logic [TIMER_W-1:0] period_min;
  logic [TIMER_W-1:0] period_max;
  logic [TIMER_W-1:0] window_interval;
  logic [TIMER_W-1:0] poll_interval;
  logic [TIMER_W-1:0] both_interval;

  // block state
  logic [TIMER_COUNT-1:0][TIMER_W-1:0] timers;
  logic [TIMER_W-1:0] blink_period;
  logic               led_pin;
  logic               led_next;
  logic               run_flag;
  logic [1:0]         latches;
  logic [1:0]         seen;

  // input register and result register
  logic    in_valid;
  tick_t   in_word;
  logic    out_valid;
  result_t out_word;
  logic    advance;

  assign advance      = in_valid && (!out_valid || result.ready);
  assign tick.ready   = !in_valid || advance;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_word;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      period_step     <= RST_PERIOD_STEP;
      period_min      <= RST_PERIOD_MIN;
      period_max      <= RST_PERIOD_MAX;
      window_interval <= RST_WINDOW_INTERVAL;
      poll_interval   <= RST_POLL_INTERVAL;
      both_interval   <= RST_BOTH_INTERVAL;
    end else if (cfg.valid) begin
      case (cfg.data.addr)
        REG_PERIOD_STEP:     period_step     <= cfg.data.data;
        REG_PERIOD_MIN:      period_min      <= cfg.data.data;
        REG_PERIOD_MAX:      period_max      <= cfg.data.data;
        REG_PERIOD_START:    ;  // reset reloads the default, nothing to hold
        REG_WINDOW_INTERVAL: window_interval <= cfg.data.data;
        REG_POLL_INTERVAL:   poll_interval   <= cfg.data.data;
        REG_BOTH_INTERVAL:   both_interval   <= cfg.data.data;
        default: ;
      endcase
    end
  end

  // ---- tick processing (single pass) ----
  logic [TIMER_COUNT-1:0]              fire;
  logic [TIMER_COUNT-1:0][TIMER_W-1:0] timers_next;
  logic [1:0]          seen_win;
  logic                stop;
  logic signed [17:0]  p_sum;
  logic [TIMER_W-1:0]  p_clamped;
  logic [TIMER_W-1:0]  blink_period_next;
  logic                led_pin_next;
  logic                led_next_next;
  logic                run_flag_next;
  logic [1:0]          latches_next;
  logic [1:0]          seen_next;
  logic [TIMER_W:0]    sat_sum [TIMER_COUNT];
  logic [TIMER_W-1:0]  t_base;

  always_comb begin
    fire[T_WINDOW] = run_flag && (timers[T_WINDOW] >= window_interval);
    fire[T_UP]     = run_flag && (timers[T_UP]     >= poll_interval);
    fire[T_DOWN]   = run_flag && (timers[T_DOWN]   >= poll_interval);
    fire[T_BOTH]   = run_flag && (timers[T_BOTH]   >= both_interval);

    seen_win = fire[T_WINDOW] ? 2'b00 : seen;
    stop     = fire[T_BOTH] && (seen_win == 2'b11);

    p_sum     = $signed({2'b00, blink_period});
    seen_next = seen_win;
    latches_next = latches;
    if (fire[T_UP]) begin
      if (latches[0]) begin
        p_sum        = p_sum + $signed({2'b00, period_step});
        seen_next[0] = 1'b1;
      end
      latches_next[0] = 1'b0;
    end
    if (fire[T_DOWN]) begin
      if (latches[1]) begin
        p_sum        = p_sum - $signed({2'b00, period_step});
        seen_next[1] = 1'b1;
      end
      latches_next[1] = 1'b0;
    end

    // raise to min, then lower to max
    if (p_sum < $signed({2'b00, period_min})) begin
      p_clamped = period_min;
    end else begin
      p_clamped = p_sum[TIMER_W-1:0];
    end
    if (p_sum > $signed({2'b00, period_max}) || period_min > period_max) begin
      if (p_sum > $signed({2'b00, period_max}) ||
          $signed({2'b00, p_clamped}) > $signed({2'b00, period_max})) begin
        p_clamped = period_max;
      end
    end

    blink_period_next = run_flag ? p_clamped : blink_period;
    fire[T_BLINK]     = run_flag && (timers[T_BLINK] >= blink_period_next);

    led_pin_next  = stop ? 1'b1 : led_pin;
    led_next_next = led_next;
    if (fire[T_BLINK]) begin
      led_pin_next  = led_next;
      led_next_next = !led_next;
    end
    run_flag_next = run_flag && !stop;

    if (run_flag) begin
      if (in_word.up_pressed)   latches_next[0] = 1'b1;
      if (in_word.down_pressed) latches_next[1] = 1'b1;
    end else begin
      latches_next = latches;
      seen_next    = seen;
    end

    for (int i = 0; i < TIMER_COUNT; i++) begin
      t_base     = fire[i] ? '0 : timers[i];
      sat_sum[i] = {1'b0, t_base} + {{(TIMER_W + 1 - ELAPSED_W){1'b0}}, in_word.elapsed_ms};
      timers_next[i] = sat_sum[i][TIMER_W] ? TIMER_MAX : sat_sum[i][TIMER_W-1:0];
    end
  end

  // control and state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      timers       <= '0;
      blink_period <= RST_PERIOD_START;
      led_pin      <= 1'b0;
      led_next     <= 1'b0;
      run_flag     <= 1'b1;
      latches      <= 2'b00;
      seen         <= 2'b00;
    end else begin
      if (tick.ready) begin
        in_valid <= tick.valid;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        timers       <= timers_next;
        blink_period <= blink_period_next;
        led_pin      <= led_pin_next;
        led_next     <= led_next_next;
        run_flag     <= run_flag_next;
        latches      <= latches_next;
        seen         <= seen_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_word <= tick.data;
    end
    if (advance) begin
      out_word.led_level   <= led_pin_next;
      out_word.running     <= run_flag_next;
      out_word.half_period <= blink_period_next;
    end
  end

endmodule
